// ----- hdl/ald_pkg.sv -----
// shared types, codes and constants for the ambient light led dimmer
`default_nettype none
package ald_pkg;

   // mode codes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_ERR  = 2'd2;
   localparam logic [1:0] MODE_OFF  = 2'd3;

   // event kinds on the request channel
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_PRESS  = 2'd2;

   // button codes
   localparam logic [1:0] BTN_UP   = 2'd0;
   localparam logic [1:0] BTN_DOWN = 2'd1;
   localparam logic [1:0] BTN_OK   = 2'd2;

   // notice codes
   localparam logic [1:0] NOTE_NONE  = 2'd0;
   localparam logic [1:0] NOTE_START = 2'd1;
   localparam logic [1:0] NOTE_OFF   = 2'd2;
   localparam logic [1:0] NOTE_DISC  = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_PWM_PERIOD = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE   = 2'd1;
   localparam logic [1:0] CSR_ALPHA      = 2'd2;

   // csr reset values
   localparam logic [15:0] PWM_PERIOD_RST = 16'd999;
   localparam logic [15:0] DEBOUNCE_RST   = 16'd200;
   localparam logic [15:0] ALPHA_RST      = 16'd3277;

   // classified commands handed from front to back
   localparam logic [2:0] CMD_NONE        = 3'd0;
   localparam logic [2:0] CMD_SAMPLE_OK   = 3'd1;
   localparam logic [2:0] CMD_SAMPLE_FAIL = 3'd2;
   localparam logic [2:0] CMD_TICK        = 3'd3;
   localparam logic [2:0] CMD_UP          = 3'd4;
   localparam logic [2:0] CMD_DOWN        = 3'd5;
   localparam logic [2:0] CMD_OK          = 3'd6;

   // raw reading of 300 lux, the point where the led goes fully off
   localparam logic [8:0] LUX_LIMIT_RAW = 9'd360;

   // floor(x / 360) = floor((x >> 3) / 45); (y * RECIP_45) >> RECIP_SHIFT is exact for y < 2^22
   localparam logic [22:0] RECIP_45    = 23'd5965233;
   localparam int          RECIP_SHIFT = 28;

   // cycles the target pipeline needs to settle after its inputs change
   localparam logic [1:0] TARGET_LAT = 2'd2;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef struct packed {
      logic [1:0]  op;
      logic        read_ok;
      logic [15:0] raw_light;
      logic [1:0]  button;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        cursor;
      logic        sensor_good;
      logic [15:0] pwm_compare;
      logic        pwm_enable;
      logic [1:0]  notice;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] raw_light;
   } cmd_type;

   typedef struct packed {
      logic [15:0] pwm_period;
      logic [15:0] debounce_ms;
      logic [15:0] smoothing_alpha;
   } csr_type;

endpackage
`default_nettype wire

// ----- hdl/ald_front.sv -----
// front end: accepts events, debounces buttons and classifies into commands
`default_nettype none
module ald_front
   import ald_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  wire  [15:0] debounce_ms,
   input  wire         queue_full,
   output logic        push,
   output cmd_type     push_cmd
);

   logic [31:0] last_press_ff, last_press_in;
   logic [31:0] elapsed;
   logic        bounced;
   logic        press_taken;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign elapsed     = req_data.now_ms - last_press_ff;
   assign bounced     = elapsed < {16'd0, debounce_ms};
   assign press_taken = (req_data.op == OP_PRESS) && (req_data.button <= BTN_OK) && !bounced;

   always_comb begin
      push_cmd.raw_light = req_data.raw_light;
      push_cmd.kind      = CMD_NONE;
      unique case (req_data.op)
         OP_SAMPLE: push_cmd.kind = req_data.read_ok ? CMD_SAMPLE_OK : CMD_SAMPLE_FAIL;
         OP_TICK:   push_cmd.kind = CMD_TICK;
         OP_PRESS: begin
            if (press_taken) begin
               unique case (req_data.button)
                  BTN_UP:   push_cmd.kind = CMD_UP;
                  BTN_DOWN: push_cmd.kind = CMD_DOWN;
                  BTN_OK:   push_cmd.kind = CMD_OK;
                  default:  push_cmd.kind = CMD_NONE;
               endcase
            end
         end
         default: push_cmd.kind = CMD_NONE;
      endcase
   end

   assign last_press_in = (push && press_taken) ? req_data.now_ms : last_press_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_press_ff <= 32'd0;
      end else begin
         last_press_ff <= last_press_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ald_queue.sv -----
// two-entry command queue between front end and back end
`default_nettype none
module ald_queue
   import ald_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      push,
   input  cmd_type  push_cmd,
   input  wire      pop,
   output logic     full,
   output logic     not_empty,
   output cmd_type  head_cmd
);

   cmd_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;

   assign full      = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_cmd  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ald_target.sv -----
// two-stage pipeline turning the stored light reading into a pwm target
`default_nettype none
module ald_target
   import ald_pkg::*;
(
   input  wire         clock,
   input  wire  [15:0] light_raw,
   input  wire  [15:0] pwm_period,
   output logic [15:0] scaled_target
);

   logic [8:0]  factor;
   logic [24:0] prod_ff, prod_in;
   logic [44:0] quot_full;
   logic [15:0] quot_ff, quot_in;

   // bright enough means the full period, which the formula gives at factor 360
   assign factor  = (light_raw >= {7'd0, LUX_LIMIT_RAW}) ? LUX_LIMIT_RAW
                                                          : LUX_LIMIT_RAW - light_raw[8:0];
   assign prod_in = pwm_period * factor;

   assign quot_full = prod_ff[24:3] * RECIP_45;
   assign quot_in   = quot_full[RECIP_SHIFT+15:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
   end

   assign scaled_target = quot_ff;

endmodule
`default_nettype wire

// ----- hdl/ald_back.sv -----
// back end: mode control, lag filter and registered result
`default_nettype none
module ald_back
   import ald_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         q_not_empty,
   input  cmd_type     head_cmd,
   output logic        pop,
   input  csr_type     csr,
   input  wire         period_write,
   input  wire  [15:0] scaled_target,
   output logic [15:0] light_raw,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data
);

   logic [1:0]  mode_ff, mode_in;
   logic        cursor_ff, cursor_in;
   logic        good_ff, good_in;
   logic [15:0] light_ff, light_in;
   logic [31:0] smooth_ff, smooth_in;
   logic [15:0] compare_ff, compare_in;
   logic [1:0]  settle_ff, settle_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        active;
   logic        stall;
   logic [1:0]  notice;
   logic [15:0] tgt;
   logic [31:0] t16;
   logic        rising;
   logic [31:0] mag;
   logic [47:0] step_full;
   logic [31:0] step;
   logic [31:0] smooth_tick;
   logic [15:0] ccr_tick;

   assign active = (mode_ff == MODE_RUN) || (mode_ff == MODE_ERR);
   assign stall  = (head_cmd.kind == CMD_TICK) && (settle_ff != 2'd0);
   assign pop    = q_not_empty && !stall && (!rsp_valid_ff || rsp_ready);

   // lag filter step
   assign tgt         = (good_ff && mode_ff == MODE_RUN) ? scaled_target : csr.pwm_period;
   assign t16         = {tgt, 16'd0};
   assign rising      = t16 >= smooth_ff;
   assign mag         = rising ? t16 - smooth_ff : smooth_ff - t16;
   assign step_full   = mag * csr.smoothing_alpha;
   assign step        = step_full[47:16];
   assign smooth_tick = rising ? smooth_ff + step : smooth_ff - step;
   assign ccr_tick    = (smooth_tick[31:16] > csr.pwm_period) ? csr.pwm_period
                                                               : smooth_tick[31:16];

   always_comb begin
      mode_in    = mode_ff;
      cursor_in  = cursor_ff;
      good_in    = good_ff;
      light_in   = light_ff;
      smooth_in  = smooth_ff;
      compare_in = compare_ff;
      notice     = NOTE_NONE;
      if (pop) begin
         case (head_cmd.kind) inside
            CMD_SAMPLE_OK: begin
               if (active) begin
                  light_in = head_cmd.raw_light;
                  good_in  = 1'b1;
                  if (!good_ff && mode_ff == MODE_ERR) begin
                     mode_in = MODE_RUN;
                  end
               end
            end
            CMD_SAMPLE_FAIL: begin
               if (active) begin
                  light_in = 16'd0;
                  good_in  = 1'b0;
                  if (mode_ff == MODE_RUN) begin
                     mode_in    = MODE_ERR;
                     compare_in = csr.pwm_period;
                     notice     = NOTE_DISC;
                  end
               end
            end
            CMD_TICK: begin
               if (active) begin
                  smooth_in  = smooth_tick;
                  compare_in = ccr_tick;
               end
            end
            CMD_UP, CMD_DOWN, CMD_OK: begin
               if (mode_ff == MODE_IDLE) begin
                  if (head_cmd.kind == CMD_UP) begin
                     cursor_in = 1'b0;
                  end else if (head_cmd.kind == CMD_DOWN) begin
                     cursor_in = 1'b1;
                  end else if (!cursor_ff) begin
                     mode_in    = MODE_RUN;
                     good_in    = 1'b0;
                     smooth_in  = {csr.pwm_period, 16'd0};
                     compare_in = csr.pwm_period;
                     notice     = NOTE_START;
                  end else begin
                     mode_in = MODE_OFF;
                     notice  = NOTE_OFF;
                  end
               end else if (active) begin
                  if (head_cmd.kind != CMD_UP) begin
                     mode_in = MODE_IDLE;
                     notice  = NOTE_OFF;
                  end
               end else if (head_cmd.kind == CMD_OK) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // tick stall counter, reloaded when the reading or period moves so the target pipeline can settle
   always_comb begin
      settle_in = settle_ff;
      if (period_write ||
          (pop && (head_cmd.kind == CMD_SAMPLE_OK || head_cmd.kind == CMD_SAMPLE_FAIL))) begin
         settle_in = TARGET_LAT;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   always_comb begin
      rsp_data_in.mode        = mode_in;
      rsp_data_in.cursor      = cursor_in;
      rsp_data_in.sensor_good = good_in;
      rsp_data_in.pwm_compare = compare_in;
      rsp_data_in.pwm_enable  = (mode_in == MODE_RUN) || (mode_in == MODE_ERR);
      rsp_data_in.notice      = notice;
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         cursor_ff    <= 1'b0;
         good_ff      <= 1'b0;
         light_ff     <= 16'd0;
         smooth_ff    <= {PWM_PERIOD_RST, 16'd0};
         compare_ff   <= PWM_PERIOD_RST;
         settle_ff    <= TARGET_LAT;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         cursor_ff    <= cursor_in;
         good_ff      <= good_in;
         light_ff     <= light_in;
         smooth_ff    <= smooth_in;
         compare_ff   <= compare_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign light_raw = light_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- hdl/ambient_light_led_dimmer.sv -----
// top level of the ambient light led dimmer
//
// Event-driven dimmer controller. Each request transaction is a sensor sample,
// a 10 ms dim tick or a button press; each one returns exactly one response
// transaction carrying mode, menu cursor, sensor status, the smoothed inverted
// pwm compare value, the pwm enable and a one-shot notice. Sustained rate is one
// transaction per clock while the receiver keeps up and no tick waits; a taken
// request passes the queue and the output register before its response is valid.
// A dim tick after a sample or pwm_period write waits for the two-multiplier target
// pipeline to settle. The front end debounces presses against now_ms and hands
// classified commands to the back end through a two-entry queue, and the result
// sits in an output register, so either side may stall independently. CSRs are
// written through csr_we/csr_index/csr_wdata with no wait state; index 0 is
// pwm_period, 1 debounce_ms, 2 smoothing_alpha, other indexes are ignored.
`default_nettype none
module ambient_light_led_dimmer
   import ald_pkg::*;
(
   input  wire         clock,
   input  wire         reset,

   // request channel
   input  wire         req_valid,
   output logic        req_ready,
   input  req_type     req_data,

   // response channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data,

   // csr write port
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   // configuration registers
   csr_type     csr_ff, csr_in;
   logic        period_write;

   // front to queue
   logic        push;
   cmd_type     push_cmd;
   logic        queue_full;

   // queue to back
   logic        pop;
   logic        q_not_empty;
   cmd_type     head_cmd;

   // target pipeline
   logic [15:0] light_raw;
   logic [15:0] scaled_target;

   assign period_write = csr_we && (csr_index == CSR_PWM_PERIOD);

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PWM_PERIOD: csr_in.pwm_period      = csr_wdata;
            CSR_DEBOUNCE:   csr_in.debounce_ms     = csr_wdata;
            CSR_ALPHA:      csr_in.smoothing_alpha = csr_wdata;
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pwm_period      <= PWM_PERIOD_RST;
         csr_ff.debounce_ms     <= DEBOUNCE_RST;
         csr_ff.smoothing_alpha <= ALPHA_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front end: takes every transaction the queue has room for
   ald_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .debounce_ms (csr_ff.debounce_ms),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decouples front from back
   ald_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // pwm target from the stored reading, free-running
   ald_target u_target (
      .clock         (clock),
      .light_raw     (light_raw),
      .pwm_period    (csr_ff.pwm_period),
      .scaled_target (scaled_target)
   );

   // back end: state update, lag filter and output register
   ald_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .csr           (csr_ff),
      .period_write  (period_write),
      .scaled_target (scaled_target),
      .light_raw     (light_raw),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule
`default_nettype wire

// ----- test/dimmer_tb_pkg.sv -----
// scoreboard class that predicts and checks the dimmer status transactions
package dimmer_tb_pkg;
   import ald_pkg::*;

   class dimmer_scoreboard;
      logic [15:0] cfg_period;
      logic [15:0] cfg_debounce;
      logic [15:0] cfg_alpha;
      logic [1:0]  mode_now;
      logic        cursor_now;
      logic        sensor_ok;
      logic [15:0] light_now;
      logic [15:0] compare_now;
      logic [31:0] filter_q16;
      logic [31:0] last_press_ms;
      rsp_type     status_due[$];
      int          mismatches;

      function new();
         cfg_period    = PWM_PERIOD_RST;
         cfg_debounce  = DEBOUNCE_RST;
         cfg_alpha     = ALPHA_RST;
         mode_now      = MODE_IDLE;
         cursor_now    = 1'b0;
         sensor_ok     = 1'b0;
         light_now     = '0;
         compare_now   = PWM_PERIOD_RST;
         filter_q16    = {PWM_PERIOD_RST, 16'h0000};
         last_press_ms = '0;
         mismatches    = 0;
      endfunction

      function void write_config(logic [1:0] reg_index, logic [15:0] reg_value);
         case (reg_index)
            CSR_PWM_PERIOD: cfg_period = reg_value;
            CSR_DEBOUNCE:   cfg_debounce = reg_value;
            CSR_ALPHA:      cfg_alpha = reg_value;
            default: ;
         endcase
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      // advance the predicted state by one accepted event and queue its status
      function void note_event(req_type item);
         logic [1:0]  note;
         logic [31:0] target;
         logic [63:0] aim;
         logic [63:0] gap;
         logic [63:0] nudge;
         rsp_type     want;
         note = NOTE_NONE;
         case (item.op)
            OP_SAMPLE: begin
               if (mode_now == MODE_RUN || mode_now == MODE_ERR) begin
                  if (item.read_ok) begin
                     light_now = item.raw_light;
                     if (!sensor_ok) begin
                        sensor_ok = 1'b1;
                        if (mode_now == MODE_ERR) mode_now = MODE_RUN;
                     end
                  end else begin
                     sensor_ok = 1'b0;
                     light_now = '0;
                     if (mode_now == MODE_RUN) begin
                        mode_now    = MODE_ERR;
                        compare_now = cfg_period;
                        note        = NOTE_DISC;
                     end
                  end
               end
            end
            OP_TICK: begin
               if (mode_now == MODE_RUN || mode_now == MODE_ERR) begin
                  if (!sensor_ok || mode_now != MODE_RUN || light_now >= 16'(LUX_LIMIT_RAW))
                     target = 32'(cfg_period);
                  else
                     target = (32'(cfg_period) * (32'(LUX_LIMIT_RAW) - 32'(light_now)))
                              / 32'(LUX_LIMIT_RAW);
                  aim = 64'(target[15:0]) << 16;
                  if (aim >= 64'(filter_q16)) begin
                     gap        = aim - 64'(filter_q16);
                     nudge      = (gap * 64'(cfg_alpha)) >> 16;
                     filter_q16 = filter_q16 + nudge[31:0];
                  end else begin
                     gap        = 64'(filter_q16) - aim;
                     nudge      = (gap * 64'(cfg_alpha)) >> 16;
                     filter_q16 = filter_q16 - nudge[31:0];
                  end
                  compare_now = (filter_q16[31:16] > cfg_period) ? cfg_period
                                                                 : filter_q16[31:16];
               end
            end
            OP_PRESS: begin
               if (item.button <= BTN_OK &&
                   (item.now_ms - last_press_ms) >= 32'(cfg_debounce)) begin
                  last_press_ms = item.now_ms;
                  case (mode_now)
                     MODE_IDLE: begin
                        if (item.button == BTN_UP) begin
                           cursor_now = 1'b0;
                        end else if (item.button == BTN_DOWN) begin
                           cursor_now = 1'b1;
                        end else if (!cursor_now) begin
                           mode_now    = MODE_RUN;
                           sensor_ok   = 1'b0;
                           filter_q16  = {cfg_period, 16'h0000};
                           compare_now = cfg_period;
                           note        = NOTE_START;
                        end else begin
                           mode_now = MODE_OFF;
                           note     = NOTE_OFF;
                        end
                     end
                     MODE_RUN, MODE_ERR: begin
                        if (item.button != BTN_UP) begin
                           mode_now = MODE_IDLE;
                           note     = NOTE_OFF;
                        end
                     end
                     default: begin
                        if (item.button == BTN_OK) mode_now = MODE_IDLE;
                     end
                  endcase
               end
            end
            default: ;
         endcase
         want.mode        = mode_now;
         want.cursor      = cursor_now;
         want.sensor_good = sensor_ok;
         want.pwm_compare = compare_now;
         want.pwm_enable  = (mode_now == MODE_RUN || mode_now == MODE_ERR);
         want.notice      = note;
         status_due.push_back(want);
      endfunction

      function void check_status(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            $error("status transaction with no event outstanding");
            mismatches++;
            return;
         end
         want = status_due.pop_front();
         if (got.mode !== want.mode) begin
            $error("mode expected %0d got %0d", want.mode, got.mode);
            mismatches++;
         end
         if (got.cursor !== want.cursor) begin
            $error("cursor expected %0d got %0d", want.cursor, got.cursor);
            mismatches++;
         end
         if (got.sensor_good !== want.sensor_good) begin
            $error("sensor_good expected %0d got %0d", want.sensor_good, got.sensor_good);
            mismatches++;
         end
         if (got.pwm_compare !== want.pwm_compare) begin
            $error("pwm_compare expected %0d got %0d", want.pwm_compare, got.pwm_compare);
            mismatches++;
         end
         if (got.pwm_enable !== want.pwm_enable) begin
            $error("pwm_enable expected %0d got %0d", want.pwm_enable, got.pwm_enable);
            mismatches++;
         end
         if (got.notice !== want.notice) begin
            $error("notice expected %0d got %0d", want.notice, got.notice);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ----- test/tb_ambient_light_led_dimmer.sv -----
// top-level testbench for the ambient light led dimmer
module tb_ambient_light_led_dimmer;
   timeunit 1ns;
   timeprecision 1ps;
   import ald_pkg::*;
   import dimmer_tb_pkg::*;

   // codes the block must ignore
   localparam logic [1:0] OP_SPARE  = 2'd3;
   localparam logic [1:0] BTN_SPARE = 2'd3;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // idle cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT   = 5000;
   // margin left after the last outstanding response is taken
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   dimmer_scoreboard book;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          stall_count;
   logic [31:0] ms_clock;
   req_type     script[$];

   ambient_light_led_dimmer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // every accepted status transaction goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_status(rsp_data);
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic req_type make_event(logic [1:0] op, logic ok, logic [15:0] raw,
                                          logic [1:0] btn, logic [31:0] stamp);
      req_type item;
      item.op        = op;
      item.read_ok   = ok;
      item.raw_light = raw;
      item.button    = btn;
      item.now_ms    = stamp;
      return item;
   endfunction

   // offer one event, with random gaps in front, and wait for its transaction
   task automatic send_event(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      book.note_event(item);
   endtask

   task automatic drain_and_settle();
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes, caller lowers it
   task automatic write_csr(input logic [1:0] reg_index, input logic [15:0] reg_value);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= reg_value;
      @(posedge clock);
      book.write_config(reg_index, reg_value);
   endtask

   // registers change only with nothing in flight
   task automatic apply_settings(input logic [15:0] period, input logic [15:0] debounce,
                                 input logic [15:0] alpha);
      drain_and_settle();
      write_csr(CSR_PWM_PERIOD, period);
      write_csr(CSR_DEBOUNCE, debounce);
      write_csr(CSR_ALPHA, alpha);
      // unused index, must leave every register alone
      write_csr(CSR_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   // random events steered by the predicted mode so most of them act:
   // presses that walk the menu while idle or off, and mostly samples and
   // ticks with an occasional exit press while running, plus some noise
   task automatic run_phase(input int count, input bit hold_midway);
      req_type item;
      int      roll;
      for (int n = 0; n < count; n++) begin
         // sender holds off until the block has answered everything
         if (hold_midway && n == count / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (book.pending() != 0) @(posedge clock);
         end
         item.read_ok = 1'($urandom_range(0, 1));
         item.button  = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 19))
            0, 1:    item.raw_light = '0;
            2:       item.raw_light = 16'd359;
            3:       item.raw_light = 16'd360;
            4:       item.raw_light = 16'hffff;
            5, 6:    item.raw_light = 16'($urandom);
            default: item.raw_light = 16'($urandom_range(0, 400));
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // noise: any op, any button, stray timestamps, clock near wrap
            item.op = 2'($urandom_range(0, 3));
            if (roll < 2) ms_clock = 32'hffff_ffff - 32'($urandom_range(0, 300));
            item.now_ms = roll[0] ? 32'($urandom) : ms_clock;
         end else begin
            roll = $urandom_range(0, 99);
            case (book.mode_now)
               MODE_IDLE: begin
                  item.op = OP_PRESS;
                  if (book.cursor_now)
                     item.button = (roll < 50) ? BTN_UP : (roll < 85) ? BTN_OK : BTN_DOWN;
                  else
                     item.button = (roll < 70) ? BTN_OK : (roll < 90) ? BTN_UP : BTN_DOWN;
               end
               MODE_OFF: begin
                  item.op     = OP_PRESS;
                  item.button = (roll < 70) ? BTN_OK : (roll < 85) ? BTN_UP : BTN_DOWN;
               end
               default: begin
                  if (roll < 4) begin
                     item.op     = OP_PRESS;
                     item.button = 2'($urandom_range(0, 2));
                  end else if (roll < 40) begin
                     item.op      = OP_SAMPLE;
                     item.read_ok = ($urandom_range(0, 99) < 90);
                  end else begin
                     item.op = OP_TICK;
                  end
               end
            endcase
            // presses mostly clear the debounce window, some land inside it
            if (item.op == OP_PRESS && $urandom_range(0, 99) < 85)
               ms_clock = ms_clock + 32'(book.cfg_debounce) + 32'($urandom_range(0, 40));
            else
               ms_clock = ms_clock + 32'($urandom_range(0, 60));
            item.now_ms = ms_clock;
         end
         send_event(item);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      book          = new();
      send_idle_pct = 25;
      recv_idle_pct = 67;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_PWM_PERIOD;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass on reset settings
      script.push_back(make_event(OP_TICK, 1'b1, 16'd0, BTN_UP, 32'd0));        // ignored in idle
      script.push_back(make_event(OP_SAMPLE, 1'b1, 16'd100, BTN_UP, 32'd0));    // ignored in idle
      script.push_back(make_event(OP_SPARE, 1'b1, 16'hffff, BTN_OK, 32'hffff_ffff));
      // spare button is ignored and does not restart the debounce window
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_SPARE, 32'd5000));
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_UP, 32'd150));     // too early
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_DOWN, 32'd200));   // on the edge
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_OK, 32'd399));     // bounce
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_OK, 32'd400));     // to off
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_UP, 32'd700));     // off ignores up
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_OK, 32'd1000));    // back to idle
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_UP, 32'd1300));
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_OK, 32'd1600));    // start
      script.push_back(make_event(OP_TICK, 1'b0, 16'd0, BTN_UP, 32'd0));       // sensor not ok
      script.push_back(make_event(OP_SAMPLE, 1'b0, 16'd50, BTN_UP, 32'd0));    // disconnect
      script.push_back(make_event(OP_SAMPLE, 1'b0, 16'd50, BTN_UP, 32'd0));    // still failing
      script.push_back(make_event(OP_SAMPLE, 1'b1, 16'd0, BTN_UP, 32'd0));     // recovery
      script.push_back(make_event(OP_TICK, 1'b0, 16'd0, BTN_UP, 32'd0));
      script.push_back(make_event(OP_SAMPLE, 1'b1, 16'd359, BTN_UP, 32'd0));
      script.push_back(make_event(OP_TICK, 1'b0, 16'd0, BTN_UP, 32'd0));
      script.push_back(make_event(OP_SAMPLE, 1'b1, 16'd360, BTN_UP, 32'd0));
      script.push_back(make_event(OP_TICK, 1'b0, 16'd0, BTN_UP, 32'd0));
      script.push_back(make_event(OP_SAMPLE, 1'b1, 16'hffff, BTN_UP, 32'd0));
      script.push_back(make_event(OP_TICK, 1'b0, 16'd0, BTN_UP, 32'd0));
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_UP, 32'd1900));    // up while running
      script.push_back(make_event(OP_PRESS, 1'b0, 16'd0, BTN_OK, 32'd2200));    // stop
      foreach (script[k]) send_event(script[k]);
      req_valid <= 1'b0;
      ms_clock = 32'd2200;

      // sender light, receiver heavy
      apply_settings(PWM_PERIOD_RST, DEBOUNCE_RST, ALPHA_RST);
      run_phase(100, 1'b0);
      apply_settings(16'hffff, 16'd0, 16'hffff);
      run_phase(100, 1'b0);

      // sender heavy, receiver light
      send_idle_pct = 67;
      recv_idle_pct = 25;
      apply_settings(16'd1, 16'hffff, 16'd1);
      run_phase(100, 1'b1);
      // zero period drives target and compare to zero
      apply_settings(16'd0, 16'd50, 16'd40000);
      run_phase(100, 1'b0);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(16'd360, 16'd1000, 16'd16384);
      run_phase(100, 1'b0);
      apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(1, 65535)));
      run_phase(100, 1'b0);

      drain_and_settle();
      if (book.mismatches == 0 && book.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
